// File: hw/rtl/tccw_pkg.sv
// Shared types and constants of the text console character writer.
package tccw_pkg;

	localparam int unsigned POS_W = 11;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_FG = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BG = 1'b1;

	localparam logic [7:0] CODE_NEWLINE = 8'h0A;
	localparam logic [7:0] CODE_TAB = 8'h09;

	typedef enum logic [1:0] {
		ACT_PUT = 2'd0,
		ACT_CLEAR = 2'd1,
		ACT_READ = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef struct packed {
		action_t action;
		logic [7:0] char_code;
		logic [10:0] cell_index;
	} req_t;

	typedef struct packed {
		logic [POS_W-1:0] cursor_position;
		logic [7:0] read_char;
		logic [3:0] read_fg;
		logic [3:0] read_bg;
		logic scrolled;
	} rsp_t;

	typedef struct packed {
		logic [3:0] bg;
		logic [3:0] fg;
		logic [7:0] ch;
	} cell_t;

	localparam cell_t BLANK_CELL = '{bg: 4'h0, fg: 4'hF, ch: 8'h00};

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_SCROLL_COPY,
		ST_SCROLL_FILL,
		ST_CLEAR,
		ST_HOLD
	} state_t;

	typedef enum logic [2:0] {
		CUR_HOLD,
		CUR_NEWLINE,
		CUR_TAB,
		CUR_ADVANCE,
		CUR_SCROLL
	} cur_op_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_CHAR,
		WR_BLANK,
		WR_COPY
	} wr_sel_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_CELL,
		RD_COPY
	} rd_sel_t;

	typedef struct packed {
		logic load_item;
		cur_op_t cur_op;
		wr_sel_t wr_sel;
		rd_sel_t rd_sel;
		logic cnt_clr;
		logic cnt_inc;
		logic scr_set;
		logic rsp_load;
		logic rsp_rdata;
	} ctrl_cmd_t;

	typedef struct packed {
		action_t action;
		logic is_newline;
		logic is_tab;
		logic at_end;
		logic index_ok;
		logic cnt_zero;
		logic cnt_keep;
		logic cnt_last;
	} dp_status_t;

endpackage

// File: hw/rtl/text_console_char_writer_unit.sv
// Top level of the text console character writer: controller, datapath and checks.
// Put, newline, tab, unused action and an out-of-range read load the result from ST_EXEC or ST_HOLD.
// A read of a stored cell goes through ST_EXEC and ST_READ, as the cell store has a registered read port.
// A scroll copies each row up and blanks the last row, and a clear blanks every cell,
// one cell a cycle through the single write port; one item is in work at a time.
// After reset every cell of the store is swept to blank with req_ready low.
module text_console_char_writer_unit #(
	parameter int unsigned SCREEN_COLUMNS = 80,
	parameter int unsigned SCREEN_ROWS = 25,
	parameter int unsigned TAB_STOP = 8
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input tccw_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_ready,
	output tccw_pkg::rsp_t rsp,
	input logic cfg_we,
	input logic [tccw_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [tccw_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tccw_pkg::*;

	localparam int unsigned TOTAL = SCREEN_COLUMNS * SCREEN_ROWS;

	ctrl_cmd_t cmd;
	dp_status_t status;

	tccw_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.status(status),
		.cmd(cmd)
	);

	tccw_datapath #(
		.SCREEN_COLUMNS(SCREEN_COLUMNS),
		.SCREEN_ROWS(SCREEN_ROWS),
		.TAB_STOP(TAB_STOP)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd(cmd),
		.status(status),
		.rsp(rsp)
	);

	// An accepted item keeps the input closed in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("input ready right after an accepted item");

	// A scrolled item leaves the cursor one past the start of the last row.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.scrolled) |->
		(rsp.cursor_position == POS_W'(TOTAL - SCREEN_COLUMNS + 1)))
		else $error("cursor wrong after a scroll");

	// The cursor never goes beyond one past the last cell.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((32'(rsp.cursor_position) <= 32'(TOTAL)) || (TOTAL >= (1 << POS_W))))
		else $error("cursor beyond the end of the screen");

endmodule

// File: hw/rtl/tccw_ctrl.sv
// Controller state machine that sequences each item and the cell store sweeps.
module tccw_ctrl (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input logic rsp_ready,
	input tccw_pkg::dp_status_t status,
	output tccw_pkg::ctrl_cmd_t cmd
);
	import tccw_pkg::*;

	state_t state_q, state_d;
	logic rsp_valid_q;
	logic slot_free;
	logic finish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign req_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		finish = 1'b0;
		cmd.load_item = 1'b0;
		cmd.cur_op = CUR_HOLD;
		cmd.wr_sel = WR_NONE;
		cmd.rd_sel = RD_NONE;
		cmd.cnt_clr = 1'b0;
		cmd.cnt_inc = 1'b0;
		cmd.scr_set = 1'b0;
		cmd.rsp_load = 1'b0;
		cmd.rsp_rdata = 1'b0;
		case (state_q)
			ST_INIT: begin
				cmd.wr_sel = WR_BLANK;
				cmd.cnt_inc = 1'b1;
				if (status.cnt_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load_item = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (status.action)
					ACT_PUT: begin
						if (status.is_newline) begin
							cmd.cur_op = CUR_NEWLINE;
							finish = 1'b1;
						end else if (status.is_tab) begin
							cmd.cur_op = CUR_TAB;
							finish = 1'b1;
						end else if (status.at_end) begin
							cmd.scr_set = 1'b1;
							cmd.cnt_clr = 1'b1;
							state_d = ST_SCROLL_COPY;
						end else begin
							cmd.wr_sel = WR_CHAR;
							cmd.cur_op = CUR_ADVANCE;
							finish = 1'b1;
						end
					end
					ACT_CLEAR: begin
						cmd.cnt_clr = 1'b1;
						state_d = ST_CLEAR;
					end
					ACT_READ: begin
						if (status.index_ok) begin
							cmd.rd_sel = RD_CELL;
							state_d = ST_READ;
						end else begin
							finish = 1'b1;
						end
					end
					default: begin
						finish = 1'b1;
					end
				endcase
			end
			ST_READ: begin
				if (slot_free) begin
					cmd.rsp_load = 1'b1;
					cmd.rsp_rdata = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_SCROLL_COPY: begin
				cmd.rd_sel = status.cnt_keep ? RD_NONE : RD_COPY;
				cmd.wr_sel = status.cnt_zero ? WR_NONE : WR_COPY;
				if (status.cnt_keep) begin
					state_d = ST_SCROLL_FILL;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			ST_SCROLL_FILL: begin
				cmd.wr_sel = WR_BLANK;
				if (status.cnt_last) begin
					cmd.cur_op = CUR_SCROLL;
					state_d = ST_EXEC;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			ST_CLEAR: begin
				cmd.wr_sel = WR_BLANK;
				if (status.cnt_last) begin
					state_d = ST_HOLD;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			ST_HOLD: begin
				if (slot_free) begin
					cmd.rsp_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (finish) begin
			if (slot_free) begin
				cmd.rsp_load = 1'b1;
				state_d = ST_IDLE;
			end else begin
				state_d = ST_HOLD;
			end
		end
	end

endmodule

// File: hw/rtl/tccw_datapath.sv
// Datapath with the cell store, cursor tracking, sweep counter and result register.
module tccw_datapath #(
	parameter int unsigned SCREEN_COLUMNS,
	parameter int unsigned SCREEN_ROWS,
	parameter int unsigned TAB_STOP
) (
	input logic clk,
	input logic arst_n,
	input tccw_pkg::req_t req,
	input logic cfg_we,
	input logic [tccw_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [tccw_pkg::CFG_DATA_W-1:0] cfg_data,
	input tccw_pkg::ctrl_cmd_t cmd,
	output tccw_pkg::dp_status_t status,
	output tccw_pkg::rsp_t rsp
);
	import tccw_pkg::*;

	localparam int unsigned TOTAL = SCREEN_COLUMNS * SCREEN_ROWS;
	localparam int unsigned KEEP = TOTAL - SCREEN_COLUMNS;
	localparam int unsigned AW = $clog2(TOTAL);
	localparam int unsigned CURW = $clog2(TOTAL + 1);
	localparam int unsigned CW = $clog2(SCREEN_COLUMNS);
	localparam int unsigned SW = CW + 2;
	localparam int unsigned TW = $clog2(TAB_STOP + 1);
	localparam logic [TW-1:0] TAB_T = TW'(TAB_STOP);
	localparam logic [TW-1:0] ROW_STEP = TW'(SCREEN_COLUMNS % TAB_STOP);
	localparam logic [TW-1:0] ROW_STEP2 = TW'((2 * SCREEN_COLUMNS) % TAB_STOP);
	localparam logic [TW-1:0] TAB_END = TW'(TOTAL % TAB_STOP);
	localparam logic [TW-1:0] TAB_SCROLL = TW'(KEEP % TAB_STOP);

	function automatic logic [TW-1:0] add_mod(input logic [TW-1:0] a, input logic [TW-1:0] b);
		logic [TW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, TAB_T}) begin
			s = s - {1'b0, TAB_T};
		end
		return s[TW-1:0];
	endfunction

	cell_t cells_q [TOTAL];
	cell_t rdata_q;
	req_t item_q;
	rsp_t rsp_q;
	logic [3:0] fg_q, bg_q;
	logic [AW-1:0] cnt_q;
	logic scr_q;

	// Cursor as a linear index, its column, its residue modulo the tab stop, and the
	// residue of the start of its row.
	logic [CURW-1:0] cursor_q, cursor_d;
	logic [CW-1:0] col_q, col_d;
	logic [TW-1:0] tab_q, tab_d;
	logic [TW-1:0] rs_q, rs_d;

	logic at_end;
	logic [TW-1:0] delta;
	logic [CURW:0] tab_sum;
	logic [SW-1:0] col_sum;
	logic [TW-1:0] rs_next_row;

	logic mem_we;
	logic [AW-1:0] waddr;
	cell_t wdata;
	logic mem_re;
	logic [AW-1:0] raddr;

	assign at_end = (cursor_q == CURW'(TOTAL));
	assign delta = TAB_T - tab_q;
	assign tab_sum = (CURW + 1)'(cursor_q) + (CURW + 1)'(delta);
	assign col_sum = SW'(col_q) + SW'(delta);
	assign rs_next_row = add_mod(rs_q, ROW_STEP);

	always_comb begin
		cursor_d = cursor_q;
		col_d = col_q;
		tab_d = tab_q;
		rs_d = rs_q;
		case (cmd.cur_op)
			CUR_NEWLINE: begin
				if (!at_end) begin
					cursor_d = cursor_q - CURW'(col_q) + CURW'(SCREEN_COLUMNS);
					col_d = '0;
					rs_d = rs_next_row;
					tab_d = rs_next_row;
				end
			end
			CUR_TAB: begin
				if (tab_sum >= (CURW + 1)'(TOTAL)) begin
					cursor_d = CURW'(TOTAL);
					col_d = '0;
					rs_d = TAB_END;
					tab_d = TAB_END;
				end else begin
					cursor_d = tab_sum[CURW-1:0];
					tab_d = '0;
					if (col_sum >= SW'(2 * SCREEN_COLUMNS)) begin
						col_d = CW'(col_sum - SW'(2 * SCREEN_COLUMNS));
						rs_d = add_mod(rs_q, ROW_STEP2);
					end else if (col_sum >= SW'(SCREEN_COLUMNS)) begin
						col_d = CW'(col_sum - SW'(SCREEN_COLUMNS));
						rs_d = rs_next_row;
					end else begin
						col_d = CW'(col_sum);
					end
				end
			end
			CUR_ADVANCE: begin
				cursor_d = cursor_q + 1'b1;
				tab_d = add_mod(tab_q, TW'(1 % TAB_STOP));
				if (col_q == CW'(SCREEN_COLUMNS - 1)) begin
					col_d = '0;
					rs_d = rs_next_row;
				end else begin
					col_d = col_q + 1'b1;
				end
			end
			CUR_SCROLL: begin
				cursor_d = CURW'(KEEP);
				col_d = '0;
				rs_d = TAB_SCROLL;
				tab_d = TAB_SCROLL;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			col_q <= '0;
			tab_q <= '0;
			rs_q <= '0;
			fg_q <= 4'hF;
			bg_q <= 4'h0;
			cnt_q <= '0;
			scr_q <= 1'b0;
		end else begin
			cursor_q <= cursor_d;
			col_q <= col_d;
			tab_q <= tab_d;
			rs_q <= rs_d;
			if (cfg_we && cfg_index == REG_FG) begin
				fg_q <= cfg_data;
			end
			if (cfg_we && cfg_index == REG_BG) begin
				bg_q <= cfg_data;
			end
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.load_item) begin
				scr_q <= 1'b0;
			end else if (cmd.scr_set) begin
				scr_q <= 1'b1;
			end
		end
	end

	always_comb begin
		mem_we = 1'b1;
		waddr = cnt_q;
		wdata = BLANK_CELL;
		case (cmd.wr_sel)
			WR_CHAR: begin
				waddr = AW'(cursor_q);
				wdata = '{bg: bg_q, fg: fg_q, ch: item_q.char_code};
			end
			WR_BLANK: begin
				waddr = cnt_q;
				wdata = BLANK_CELL;
			end
			WR_COPY: begin
				waddr = cnt_q - 1'b1;
				wdata = rdata_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		mem_re = 1'b1;
		raddr = cnt_q + AW'(SCREEN_COLUMNS);
		case (cmd.rd_sel)
			RD_CELL: raddr = AW'(item_q.cell_index);
			RD_COPY: raddr = cnt_q + AW'(SCREEN_COLUMNS);
			default: mem_re = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cells_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rdata_q <= cells_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= req;
		end
		if (cmd.rsp_load) begin
			rsp_q.cursor_position <= POS_W'(cursor_d);
			rsp_q.read_char <= cmd.rsp_rdata ? rdata_q.ch : 8'h00;
			rsp_q.read_fg <= cmd.rsp_rdata ? rdata_q.fg : 4'h0;
			rsp_q.read_bg <= cmd.rsp_rdata ? rdata_q.bg : 4'h0;
			rsp_q.scrolled <= scr_q;
		end
	end

	assign rsp = rsp_q;

	assign status.action = item_q.action;
	assign status.is_newline = (item_q.char_code == CODE_NEWLINE);
	assign status.is_tab = (item_q.char_code == CODE_TAB);
	assign status.at_end = at_end;
	assign status.index_ok = (32'(item_q.cell_index) < 32'(TOTAL));
	assign status.cnt_zero = (cnt_q == '0);
	assign status.cnt_keep = (cnt_q == AW'(KEEP));
	assign status.cnt_last = (cnt_q == AW'(TOTAL - 1));

endmodule
